// ===== rtl/hamdec_pkg.sv =====
// ----------------------------------------------------------------------------
// hamdec_pkg
// Shared types and constants for the hold-and-modify pixel decoder: stream
// field layout, action codes and the request record passed through the queue.
// ----------------------------------------------------------------------------
package hamdec_pkg;

    // Palette size default and request queue depth.
    localparam int PALETTE_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH       = 4;

    // Pixel group shape.
    localparam int PIX_PER_GROUP = 8;
    localparam int PIX_CNT_W     = $clog2(PIX_PER_GROUP);
    localparam int NUM_PLANES    = 8;
    localparam int PLANE_W       = 8;
    localparam int PIX_W         = NUM_PLANES;

    // Field widths.
    localparam int IDX_W   = 6;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 6;
    localparam int OUT_W   = 8;

    // Stream layout: index, color, then plane bytes 0 to 7, padded to bytes.
    localparam int PLANE_LSB  = IDX_W + COLOR_W;
    localparam int S_TDATA_W  = 96;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 3 * OUT_W;

    // Request kinds.
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_GROUP   = 1'b1;

    // Decode modes.
    localparam logic MODE_HAM6 = 1'b0;
    localparam logic MODE_HAM8 = 1'b1;

    // Per-pixel actions.
    localparam logic [1:0] ACT_PALETTE = 2'd0;
    localparam logic [1:0] ACT_BLUE    = 2'd1;
    localparam logic [1:0] ACT_RED     = 2'd2;
    localparam logic [1:0] ACT_GREEN   = 2'd3;

    // One classified pixel: action and its color operand.
    typedef struct packed {
        logic [1:0]        code;
        logic [CHAN_W-1:0] colour;
    } pix_op_t;

    // One queued request; pixel ops are meaningful for groups only.
    typedef struct packed {
        logic                               kind;
        logic                               row_start;
        logic [IDX_W-1:0]                   index;
        logic [COLOR_W-1:0]                 color;
        pix_op_t [PIX_PER_GROUP-1:0]        pix;
    } req_t;

endpackage

// ===== rtl/hamdec_ram.sv =====
// ----------------------------------------------------------------------------
// hamdec_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
module hamdec_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds while the read is not enabled.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/hamdec_front.sv =====
// ----------------------------------------------------------------------------
// hamdec_front
// Accepts requests, gathers each pixel's bits across the planes, splits them
// into action and color by mode, and queues the result for the back end.
// ----------------------------------------------------------------------------
module hamdec_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ham_mode,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] palette_index, [29:6] palette_color, [37:30] plane_byte_0 ...
    // [93:86] plane_byte_7, [95:94] zero
    input  logic [hamdec_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] kind, [1] row_start
    input  logic [hamdec_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                              q_valid,
    output hamdec_pkg::req_t                  q_req,
    input  logic                              q_pop
);
    import hamdec_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    req_t             new_req;
    req_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;

    // Classify the incoming request and transpose planes into pixels.
    always_comb begin
        logic [PIX_W-1:0] pix_bits;
        new_req.kind      = s_axis_tuser[0];
        new_req.row_start = s_axis_tuser[1];
        new_req.index     = s_axis_tdata[IDX_W-1:0];
        new_req.color     = s_axis_tdata[PLANE_LSB-1:IDX_W];
        for (int k = 0; k < PIX_PER_GROUP; k++) begin
            // Leftmost pixel comes from bit 7 of each plane byte.
            for (int p = 0; p < NUM_PLANES; p++) begin
                pix_bits[p] = s_axis_tdata[PLANE_LSB + PLANE_W * p + (PLANE_W - 1 - k)];
            end
            if (ham_mode == MODE_HAM8) begin
                new_req.pix[k].code   = pix_bits[7:6];
                new_req.pix[k].colour = pix_bits[5:0];
            end else begin
                new_req.pix[k].code   = pix_bits[5:4];
                new_req.pix[k].colour = {2'b00, pix_bits[3:0]};
            end
        end
    end

    assign s_axis_tready = (count_reg != FULL_CNT);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign q_req         = queue_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_req;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/hamdec_back.sv =====
// ----------------------------------------------------------------------------
// hamdec_back
// Executes queued requests in order: palette writes go to the palette RAM,
// pixel groups step one pixel per cycle unless the output stalls, through a
// palette read stage that updates the held color and an output register.
// ----------------------------------------------------------------------------
module hamdec_back #(
    parameter int PALETTE_DEPTH = hamdec_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ham_mode,
    input  logic                              q_valid,
    input  hamdec_pkg::req_t                  q_req,
    output logic                              q_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [hamdec_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast
);
    import hamdec_pkg::*;

    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [IDX_W:0]     DEPTH_LIM = (IDX_W + 1)'(PALETTE_DEPTH);
    localparam logic [PIX_CNT_W-1:0] LAST_PIX = PIX_CNT_W'(PIX_PER_GROUP - 1);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb6_t;

    // Palette color to held channels: keep the top bits the mode uses.
    function automatic rgb6_t to_held(input logic [COLOR_W-1:0] c, input logic ham8);
        rgb6_t h;
        if (ham8) begin
            h.red   = c[23:18];
            h.green = c[15:10];
            h.blue  = c[7:2];
        end else begin
            h.red   = {2'b00, c[23:20]};
            h.green = {2'b00, c[15:12]};
            h.blue  = {2'b00, c[7:4]};
        end
        return h;
    endfunction

    // Held channel to 8 bits by replicating its top bits.
    function automatic logic [OUT_W-1:0] widen(input logic [CHAN_W-1:0] v, input logic ham8);
        return ham8 ? {v, v[5:4]} : {v[3:0], v[3:0]};
    endfunction

    logic                     advance, a_fire, a_write, a_pix;
    logic [PIX_CNT_W-1:0]     k_reg;
    pix_op_t                  cur_op;
    logic                     wr_in_range, rd_in_range, ram_we;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic [COLOR_W-1:0]       ram_rdata;
    logic [PALETTE_DEPTH-1:0] entry_valid_reg;
    logic [COLOR_W-1:0]       entry0_reg;

    logic                     b_valid_reg, b_row_reg, b_last_reg, b_ok_reg;
    pix_op_t                  b_op_reg;
    rgb6_t                    held_reg, held_next, held_base;
    logic [COLOR_W-1:0]       pal_color;

    logic                     out_valid_reg, out_last_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;

    // Whole pipeline moves when the output register can take a pixel.
    assign advance = !out_valid_reg || m_axis_tready;
    assign a_fire  = advance && q_valid;
    assign a_write = a_fire && (q_req.kind == KIND_PALETTE);
    assign a_pix   = a_fire && (q_req.kind == KIND_GROUP);
    assign cur_op  = q_req.pix[k_reg];
    assign q_pop   = a_write || (a_pix && (k_reg == LAST_PIX));

    // Palette addressing; entries beyond the depth are never stored.
    assign wr_in_range = ({1'b0, q_req.index} < DEPTH_LIM);
    assign rd_in_range = ({1'b0, cur_op.colour} < DEPTH_LIM);
    assign wr_addr     = q_req.index[ADDR_W-1:0];
    assign rd_addr     = cur_op.colour[ADDR_W-1:0];
    assign ram_we      = a_write && wr_in_range;

    hamdec_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (q_req.color),
        .rd_en   (a_pix),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Written flags and a copy of entry 0 for row starts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            entry0_reg      <= '0;
        end else if (ram_we) begin
            entry_valid_reg[wr_addr] <= 1'b1;
            if (q_req.index == '0) begin
                entry0_reg <= q_req.color;
            end
        end
    end

    // Pixel counter within the current group.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else if (a_pix) begin
            k_reg <= (k_reg == LAST_PIX) ? '0 : k_reg + 1'b1;
        end
    end

    // Read stage: pixel op waits here for the palette data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg <= a_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_pix) begin
            b_op_reg   <= cur_op;
            b_row_reg  <= q_req.row_start && (k_reg == '0);
            b_last_reg <= (k_reg == LAST_PIX);
            b_ok_reg   <= rd_in_range && entry_valid_reg[rd_addr];
        end
    end

    // Held color update for the pixel in the read stage.
    always_comb begin
        held_base = b_row_reg ? to_held(entry0_reg, ham_mode) : held_reg;
        pal_color = b_ok_reg ? ram_rdata : '0;
        held_next = held_base;
        case (b_op_reg.code)
            ACT_PALETTE: held_next       = to_held(pal_color, ham_mode);
            ACT_BLUE:    held_next.blue  = b_op_reg.colour;
            ACT_RED:     held_next.red   = b_op_reg.colour;
            ACT_GREEN:   held_next.green = b_op_reg.colour;
            default:     held_next       = held_base;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (advance && b_valid_reg) begin
            held_reg <= held_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && b_valid_reg) begin
            out_data_reg <= {widen(held_next.blue, ham_mode),
                             widen(held_next.green, ham_mode),
                             widen(held_next.red, ham_mode)};
            out_last_reg <= b_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/planar_ham_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// planar_ham_pixel_decoder
// Hold-and-modify (HAM6 / HAM8) bitplane decoder with a stream interface.
// ----------------------------------------------------------------------------
// A palette request writes one 24-bit color in the back end; a pixel-group
// request yields eight RGB pixels, leftmost first, at one pixel per cycle
// while the output is not stalled. That rate is set by the single palette
// RAM read port, which serves one pixel per cycle, and by the held color,
// which each pixel updates in turn. A pixel issued from the head of the
// queue passes a palette read stage, then the output register, so with an
// idle block the first pixel of a group is presented once the group has
// passed through the queue and both registers, and the others follow one
// per cycle while the output is not stalled. A four-deep request queue
// sits between the input and the back end, so input is taken while results
// are stalled, until the queue is full. The palette needs no clearing pass
// after reset: per-entry written flags make unwritten entries read as black.
// ham_mode must only be written while the block is idle.
// ----------------------------------------------------------------------------
module planar_ham_pixel_decoder #(
    parameter int PALETTE_DEPTH = hamdec_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Mode register: 0 = HAM6, 1 = HAM8.
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] palette_index, [29:6] palette_color, [37:30] plane_byte_0,
    // [45:38] plane_byte_1, [53:46] plane_byte_2, [61:54] plane_byte_3,
    // [69:62] plane_byte_4, [77:70] plane_byte_5, [85:78] plane_byte_6,
    // [93:86] plane_byte_7, [95:94] zero
    input  logic [hamdec_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] kind, [1] row_start
    input  logic [hamdec_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [hamdec_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // last_of_group
    output logic                              m_axis_tlast
);
    import hamdec_pkg::*;

    logic ham_mode_reg;
    logic q_valid, q_pop;
    req_t q_req;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ham_mode_reg <= MODE_HAM6;
        end else if (cfg_wr_en) begin
            ham_mode_reg <= cfg_wr_data;
        end
    end

    hamdec_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ham_mode      (ham_mode_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .q_pop         (q_pop)
    );

    hamdec_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ham_mode      (ham_mode_reg),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
